### rtl/core/cals_pkg.sv
// Shared types and constants for the cubic arc length block.
package cals_pkg;

	// Operation codes of the shared arithmetic unit
	typedef enum logic [2:0] {
		OP_MUL  = 3'b001,
		OP_DIV  = 3'b010,
		OP_SQRT = 3'b100
	} unit_op_t;

	// Request word handed to the shared unit at start
	typedef struct packed {
		unit_op_t    op;
		logic [63:0] a;
		logic [63:0] b;
	} unit_req_t;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_CUBIC  = 2'd0;
	localparam logic [1:0] REG_SQUARE = 2'd1;
	localparam logic [1:0] REG_LINEAR = 2'd2;

	localparam logic [47:0] LEN_MAX   = 48'hFFFF_FFFF_FFFF;
	localparam logic [61:0] LIM_Q32   = 62'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [30:0] LIM_SLOPE = 31'h7FFF_FFFF;

endpackage

### rtl/core/cals_unit.sv
// Shared bit-serial multiplier, restoring divider and square root unit.
module cals_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cals_pkg::unit_req_t req,
	output logic                done,
	output logic [63:0]         res_lo,
	output logic [63:0]         res_hi
);
	import cals_pkg::*;

	unit_op_t    op_q;
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] hi_q;
	logic [63:0] lo_q;
	logic [63:0] mc_q;

	logic [64:0] mul_sum;
	logic [64:0] div_t;
	logic        div_ge;
	logic [64:0] div_diff;
	logic [63:0] sq_trial;
	logic        sq_ge;

	// One add, subtract or compare per step
	always_comb begin
		mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : 65'd0);
		div_t    = {hi_q, lo_q[63]};
		div_ge   = div_t >= {1'b0, mc_q};
		div_diff = div_t - {1'b0, mc_q};
		sq_trial = lo_q + mc_q;
		sq_ge    = hi_q >= sq_trial;
	end

	// Load operands, then advance one step a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				case (req.op)
					OP_DIV:  cnt_q <= 6'd63;
					default: cnt_q <= 6'd31;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			case (req.op)
				OP_DIV: begin
					hi_q <= 64'd0;
					lo_q <= req.a;
					mc_q <= req.b;
				end
				OP_SQRT: begin
					hi_q <= req.a;
					lo_q <= 64'd0;
					mc_q <= 64'h4000_0000_0000_0000;
				end
				default: begin
					hi_q <= 64'd0;
					lo_q <= {32'd0, req.b[31:0]};
					mc_q <= req.a;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				OP_DIV: begin
					hi_q <= div_ge ? div_diff[63:0] : div_t[63:0];
					lo_q <= {lo_q[62:0], div_ge};
				end
				OP_SQRT: begin
					if (sq_ge) begin
						hi_q <= hi_q - sq_trial;
						lo_q <= {1'b0, lo_q[63:1]} + mc_q;
					end else begin
						lo_q <= {1'b0, lo_q[63:1]};
					end
					mc_q <= {2'b00, mc_q[63:2]};
				end
				default: begin
					hi_q <= mul_sum[64:1];
					lo_q <= {mul_sum[0], lo_q[63:1]};
				end
			endcase
		end
	end

	// Product is {hi, lo[63:32]}; quotient and remainder sit in lo and hi
	always_comb begin
		done = done_q;
		case (op_q)
			OP_MUL: begin
				res_lo = {hi_q[31:0], lo_q[63:32]};
				res_hi = {32'd0, hi_q[63:32]};
			end
			default: begin
				res_lo = lo_q;
				res_hi = hi_q;
			end
		endcase
	end

endmodule

### rtl/core/cubic_arc_length_simpson.sv
// Top level of the cubic arc length block: sequencer, registers and stream ports.
// Each input word gives the arc length of y = a x^3 + b x^2 + c x over [start_x, end_x]
// by the composite Simpson rule with n+1 samples (n clamped to MAX_INTERVALS, odd
// rounded up). All multiplies, divides and square roots run on one shared bit-serial unit: per
// sample two multiplies for the slope, one for its square and a square root; the span is
// divided once and the sum is scaled by two divides and two multiplies at the end. An empty
// range or a zero count skips the unit and gives a zero length. s_tready is low while an item
// is in work; a finished result waits in the output register while the next word is taken.
module cubic_arc_length_simpson #(
	parameter int MAX_INTERVALS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // start_x[31:0], end_x[63:32], interval_count[74:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // arc_length[47:0]
	output logic        m_tuser,   // overflow[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import cals_pkg::*;

	localparam int NW = $clog2(MAX_INTERVALS + 2);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b000000000001,
		ST_SPAN_DIV = 12'b000000000010,
		ST_MUL1     = 12'b000000000100,
		ST_MUL2     = 12'b000000001000,
		ST_MUL3     = 12'b000000010000,
		ST_SQRT     = 12'b000000100000,
		ST_FIN_DIV  = 12'b000001000000,
		ST_FIN_MUL1 = 12'b000010000000,
		ST_FIN_MUL2 = 12'b000100000000,
		ST_FIN_DIV2 = 12'b001000000000,
		ST_DONE     = 12'b010000000000,
		ST_SPARE    = 12'b100000000000
	} state_t;

	state_t state_q;

	logic signed [47:0] coef_a_q, coef_b_q, coef_c_q;
	logic signed [31:0] x0_q, x_q;
	logic [31:0]        span_q, off_q, qinc_q;
	logic [NW-1:0]      n_q, i_q, rinc_q, rem_q;
	logic signed [63:0] t_q;
	logic [30:0]        m_q;
	logic [63:0]        v_q, acc_q, q_q, r_q, len_q, prod_q;
	logic               ov_q, wait_q;
	logic [47:0]        out_len_q;
	logic               out_ov_q, out_valid_q, res_ov_q;
	logic [47:0]        res_len_q;

	unit_req_t   req;
	logic        u_start, u_done;
	logic [63:0] u_lo, u_hi;

	cals_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (u_start),
		.req    (req),
		.done   (u_done),
		.res_lo (u_lo),
		.res_hi (u_hi)
	);

	// Configuration port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:3])
				REG_CUBIC:  coef_a_q <= pwdata[47:0];
				REG_SQUARE: coef_b_q <= pwdata[47:0];
				REG_LINEAR: coef_c_q <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_CUBIC:  prdata = {16'd0, coef_a_q};
			REG_SQUARE: prdata = {16'd0, coef_b_q};
			REG_LINEAR: prdata = {16'd0, coef_c_q};
			default:    prdata = 64'd0;
		endcase
	end

	// Input decode
	logic signed [31:0] in_x0, in_x1;
	logic [31:0]        cnt32, ncl32, nrnd32;
	always_comb begin
		in_x0  = s_tdata[31:0];
		in_x1  = s_tdata[63:32];
		cnt32  = {21'd0, s_tdata[74:64]};
		ncl32  = (cnt32 > 32'(MAX_INTERVALS)) ? 32'(MAX_INTERVALS) : cnt32;
		nrnd32 = ncl32 + {31'd0, ncl32[0]};
	end

	// Operand helpers
	logic signed [49:0] a3;
	logic [49:0]        a3_mag;
	logic [31:0]        x_mag;
	logic [63:0]        t_mag;
	logic [NW+1:0]      tot;
	always_comb begin
		a3     = {{2{coef_a_q[47]}}, coef_a_q} + {coef_a_q[47], coef_a_q, 1'b0};
		a3_mag = a3[49] ? 50'(-a3) : a3;
		x_mag  = x_q[31] ? 32'(-x_q) : x_q;
		t_mag  = t_q[63] ? 64'(-t_q) : t_q;
		tot    = {1'b0, n_q, 1'b0} + {2'b00, n_q};
	end

	// Select operands for the step in work
	always_comb begin
		req.op = OP_MUL;
		req.a  = 64'd0;
		req.b  = 64'd0;
		case (state_q)
			ST_SPAN_DIV: begin
				req.op = OP_DIV;
				req.a  = {32'd0, span_q};
				req.b  = 64'(n_q);
			end
			ST_MUL1: begin
				req.a = 64'(a3_mag);
				req.b = {32'd0, x_mag};
			end
			ST_MUL2: begin
				req.a = t_mag;
				req.b = {32'd0, x_mag};
			end
			ST_MUL3: begin
				req.a = {33'd0, m_q};
				req.b = {33'd0, m_q};
			end
			ST_SQRT: begin
				req.op = OP_SQRT;
				req.a  = v_q;
			end
			ST_FIN_DIV: begin
				req.op = OP_DIV;
				req.a  = acc_q;
				req.b  = 64'(tot);
			end
			ST_FIN_MUL1: begin
				req.a = q_q;
				req.b = {32'd0, span_q};
			end
			ST_FIN_MUL2: begin
				req.a = r_q;
				req.b = {32'd0, span_q};
			end
			ST_FIN_DIV2: begin
				req.op = OP_DIV;
				req.a  = prod_q;
				req.b  = 64'(tot);
			end
			default: ;
		endcase
	end

	logic calc;
	always_comb begin
		case (state_q)
			ST_SPAN_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_SQRT,
			ST_FIN_DIV, ST_FIN_MUL1, ST_FIN_MUL2, ST_FIN_DIV2: calc = 1'b1;
			default: calc = 1'b0;
		endcase
	end
	assign u_start = calc && !wait_q;

	// Round a slope product to Q.32, then add and saturate; round the slope magnitude to Q.16
	logic [95:0]        prod96, rnd96;
	logic [79:0]        res80;
	logic               mul_sat, mul_neg;
	logic [61:0]        mr_mag;
	logic signed [63:0] mr_val, addend, sum64, sat64;
	logic               add_sat;
	logic [63:0]        sat_mag;
	logic [46:0]        pm47;
	logic               pm_sat;
	logic [30:0]        pm;
	always_comb begin
		prod96  = {u_hi[31:0], u_lo};
		rnd96   = prod96 + 96'h8000;
		res80   = rnd96[95:16];
		mul_sat = res80 > {18'd0, LIM_Q32};
		mr_mag  = mul_sat ? LIM_Q32 : res80[61:0];
		mul_neg = (state_q == ST_MUL1) ? (coef_a_q[47] ^ x_q[31]) : (t_q[63] ^ x_q[31]);
		mr_val  = mul_neg ? -$signed({2'b00, mr_mag}) : $signed({2'b00, mr_mag});
		addend  = (state_q == ST_MUL1) ? 64'($signed({coef_b_q, 1'b0})) : 64'(coef_c_q);
		sum64   = mr_val + addend;
		add_sat = 1'b0;
		sat64   = sum64;
		if (sum64 > $signed({2'b00, LIM_Q32})) begin
			add_sat = 1'b1;
			sat64   = $signed({2'b00, LIM_Q32});
		end else if (sum64 < -$signed({2'b00, LIM_Q32})) begin
			add_sat = 1'b1;
			sat64   = -$signed({2'b00, LIM_Q32});
		end
		sat_mag = sat64[63] ? 64'(-sat64) : sat64;
		pm47    = 47'((sat_mag + 64'h8000) >> 16);
		pm_sat  = pm47 > {16'd0, LIM_SLOPE};
		pm      = pm_sat ? LIM_SLOPE : pm47[30:0];
	end

	// Sample weight and next sample point
	logic [63:0]   s_w;
	logic [NW:0]   rsum;
	logic          wrap;
	logic [31:0]   off_n;
	always_comb begin
		if (i_q == '0 || i_q == n_q)
			s_w = {32'd0, u_lo[31:0]};
		else if (i_q[0])
			s_w = {30'd0, u_lo[31:0], 2'b00};
		else
			s_w = {31'd0, u_lo[31:0], 1'b0};
		rsum  = {1'b0, rem_q} + {1'b0, rinc_q};
		wrap  = rsum >= {1'b0, n_q};
		off_n = off_q + qinc_q + {31'd0, wrap};
	end

	// Final sum and rounding
	logic [64:0] len_sum, len_rnd;
	logic        len_sat;
	always_comb begin
		len_sum = {1'b0, len_q} + {1'b0, u_lo};
		len_rnd = (len_sum + 65'h8000) >> 16;
		len_sat = len_rnd > {17'd0, LEN_MAX};
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
			ov_q        <= 1'b0;
			i_q         <= '0;
			n_q         <= '0;
		end else begin
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			if (u_start)
				wait_q <= 1'b1;
			if (u_done)
				wait_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						x0_q   <= in_x0;
						x_q    <= in_x0;
						span_q <= 32'(in_x1 - in_x0);
						n_q    <= NW'(nrnd32);
						i_q    <= '0;
						ov_q   <= 1'b0;
						if (in_x1 <= in_x0 || cnt32 == 32'd0) begin
							res_len_q <= 48'd0;
							res_ov_q  <= 1'b0;
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_SPAN_DIV;
						end
					end
				end
				ST_SPAN_DIV: if (u_done) begin
					qinc_q  <= u_lo[31:0];
					rinc_q  <= u_hi[NW-1:0];
					i_q     <= '0;
					off_q   <= 32'd0;
					rem_q   <= '0;
					acc_q   <= 64'd0;
					state_q <= ST_MUL1;
				end
				ST_MUL1: if (u_done) begin
					t_q     <= sat64;
					ov_q    <= ov_q | mul_sat | add_sat;
					state_q <= ST_MUL2;
				end
				ST_MUL2: if (u_done) begin
					m_q     <= pm;
					ov_q    <= ov_q | mul_sat | add_sat | pm_sat;
					state_q <= ST_MUL3;
				end
				ST_MUL3: if (u_done) begin
					v_q     <= u_lo + 64'h1_0000_0000;
					state_q <= ST_SQRT;
				end
				ST_SQRT: if (u_done) begin
					acc_q <= acc_q + s_w;
					if (i_q == n_q) begin
						state_q <= ST_FIN_DIV;
					end else begin
						i_q     <= i_q + 1'b1;
						rem_q   <= wrap ? NW'(rsum - {1'b0, n_q}) : rsum[NW-1:0];
						off_q   <= off_n;
						x_q     <= x0_q + $signed(off_n);
						state_q <= ST_MUL1;
					end
				end
				ST_FIN_DIV: if (u_done) begin
					q_q     <= u_lo;
					r_q     <= u_hi;
					state_q <= ST_FIN_MUL1;
				end
				ST_FIN_MUL1: if (u_done) begin
					len_q   <= u_lo;
					state_q <= ST_FIN_MUL2;
				end
				ST_FIN_MUL2: if (u_done) begin
					prod_q  <= u_lo;
					state_q <= ST_FIN_DIV2;
				end
				ST_FIN_DIV2: if (u_done) begin
					res_ov_q  <= ov_q | len_sat;
					res_len_q <= (ov_q | len_sat) ? LEN_MAX : len_rnd[47:0];
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_len_q <= res_len_q;
			out_ov_q  <= res_ov_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_len_q;
	assign m_tuser  = out_ov_q;

`ifndef SYNTH
	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> wait_q)
		else $error("unit finished with no request pending");
	a_sample_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (i_q <= n_q))
		else $error("sample index ran past interval count");
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == LEN_MAX))
		else $error("overflow flagged without saturated length");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the cubic arc length block: stream stimulus, APB setup, scoreboard.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cals_pkg::*;

	// Expected arc length and overflow flag for one input word
	typedef struct {
		logic [47:0] len;
		logic        ovf;
	} arc_result_t;

	// Arc length predictor and queue of expected results
	class arc_scoreboard;
		logic [47:0] coef_a, coef_b, coef_c;
		arc_result_t expected_q[$];
		int errors;
		bit sat;

		function new();
			coef_a = '0;
			coef_b = '0;
			coef_c = '0;
			errors = 0;
		endfunction

		function void report(string what);
			$display("mismatch: %s", what);
			errors++;
		endfunction

		function longint unsigned mag(longint signed v);
			return v < 0 ? longint'(0) - v : v;
		endfunction

		// Exact product, shift with rounding half away from zero, saturate in magnitude
		function longint signed mul_rnd(longint signed p, longint signed q, int sh,
				longint unsigned lim);
			logic [127:0] prod;
			logic [127:0] res;
			prod = {64'd0, mag(p)} * {64'd0, mag(q)};
			prod = prod + (128'd1 << (sh - 1));
			res = prod >> sh;
			if (res > {64'd0, lim}) begin
				sat = 1'b1;
				res = {64'd0, lim};
			end
			return ((p < 0) != (q < 0)) ? -longint'(res[63:0]) : longint'(res[63:0]);
		endfunction

		function longint signed add_sat(longint signed x, longint signed y,
				longint signed lim);
			longint signed r;
			r = x + y;
			if (r > lim) begin
				sat = 1'b1;
				r = lim;
			end
			if (r < -lim) begin
				sat = 1'b1;
				r = -lim;
			end
			return r;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, bt;
			res = 0;
			bt = 64'd1 << 62;
			while (bt > v)
				bt >>= 2;
			while (bt != 0) begin
				if (v >= res + bt) begin
					v -= res + bt;
					res = (res >> 1) + bt;
				end else begin
					res >>= 1;
				end
				bt >>= 2;
			end
			return res;
		endfunction

		// sqrt(1 + slope^2) at one sample, Q.16
		function longint unsigned slope_norm(longint signed x);
			longint signed a, b, c, t, p;
			longint unsigned m, lq, ls;
			a = longint'(signed'(coef_a));
			b = longint'(signed'(coef_b));
			c = longint'(signed'(coef_c));
			lq = {2'b0, LIM_Q32};
			ls = {33'b0, LIM_SLOPE};
			t = mul_rnd(3 * a, x, 16, lq);
			t = add_sat(t, 2 * b, lq);
			t = mul_rnd(t, x, 16, lq);
			t = add_sat(t, c, lq);
			p = mul_rnd(t, 1, 16, ls);
			m = mag(p);
			return int_sqrt(m * m + (64'd1 << 32));
		endfunction

		// Note an accepted input word and queue its arc length
		function void note_input(logic [31:0] sx, logic [31:0] ex, logic [10:0] cnt);
			longint signed x0, x1, x;
			longint unsigned n, span, acc, w, tot, q, r, len;
			arc_result_t e;
			x0 = longint'(signed'(sx));
			x1 = longint'(signed'(ex));
			n = 64'(cnt);
			sat = 1'b0;
			if (x1 <= x0 || n == 0) begin
				e.len = '0;
				e.ovf = 1'b0;
				expected_q.push_back(e);
				return;
			end
			if (n > 1024)
				n = 1024;
			if (n[0])
				n++;
			span = x1 - x0;
			acc = 0;
			for (longint unsigned i = 0; i <= n; i++) begin
				x = x0 + longint'((span * i) / n);
				w = (i == 0 || i == n) ? 1 : (i[0] ? 4 : 2);
				acc += w * slope_norm(x);
			end
			tot = 3 * n;
			q = acc / tot;
			r = acc % tot;
			len = q * span + (r * span) / tot;
			len = (len + (64'd1 << 15)) >> 16;
			if (len > {16'd0, LEN_MAX})
				sat = 1'b1;
			e.len = sat ? LEN_MAX : len[47:0];
			e.ovf = sat;
			expected_q.push_back(e);
		endfunction

		// Check one output word against the oldest expectation
		function void check(logic [47:0] len, logic ovf);
			arc_result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected word len=%h ovf=%b", len, ovf));
				return;
			end
			e = expected_q.pop_front();
			if (len !== e.len)
				report($sformatf("arc_length %h, expected %h", len, e.len));
			if (ovf !== e.ovf)
				report($sformatf("overflow %b, expected %b", ovf, e.ovf));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	arc_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	int hold_cnt;

	cubic_arc_length_simpson u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Drive the receiver: random stalls plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req <= 1'b0;
			hold_cnt <= 20000;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check each accepted output word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata, m_tuser);
	end

	// Write one coefficient register over APB
	task automatic write_coef(logic [1:0] idx, logic [47:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 3'b000};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_CUBIC: sb.coef_a = val;
			REG_SQUARE: sb.coef_b = val;
			default: sb.coef_c = val;
		endcase
		@(posedge clk);
	endtask

	// Offer one word, with random idle cycles ahead of it, until accepted
	task automatic send_item(logic [31:0] sx, logic [31:0] ex, logic [10:0] cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, cnt, ex, sx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(sx, ex, cnt);
	endtask

	// Drop valid and wait until every expected word has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [47:0] rand_coef();
		case ($urandom_range(3))
			0: return 48'(signed'($urandom_range(65535)) - 32768) <<< 16;
			1: return 48'(signed'({$urandom, $urandom} >>> 30));
			2: return 48'({$urandom, $urandom});
			default: return $urandom_range(1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
		endcase
	endfunction

	task automatic send_random();
		logic [31:0] sx, ex;
		logic [10:0] cnt;
		int k;
		k = $urandom_range(99);
		if (k < 50) begin
			sx = 32'($urandom_range(32'h1F_FFFF)) - 32'h10_0000;
			ex = sx + 32'($urandom_range(32'h10_0000)) - 32'h1000;
		end else if (k < 80) begin
			sx = $urandom;
			ex = $urandom;
		end else begin
			sx = 32'($urandom_range(32'hFFFF)) - 32'h8000;
			ex = $urandom;
		end
		k = $urandom_range(99);
		if (k < 86)
			cnt = 11'($urandom_range(24));
		else if (k < 98)
			cnt = 11'($urandom_range(64));
		else
			cnt = 11'($urandom);
		send_item(sx, ex, cnt);
	endtask

	// Stop a hung run
	initial begin
		#200ms;
		$display("[cubic_arc_length_simpson] ERROR");
		$finish;
	end

	// Main sequence: reset, directed words, then phases of random words
	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		hold_cnt = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Flat curve at reset values: length equals the span, or zero for an empty range or a zero count
		send_item(32'h0001_0000, 32'h0001_0000, 11'd4);
		send_item(32'h0002_0000, 32'h0001_0000, 11'd4);
		send_item(32'h0000_0000, 32'h0005_0000, 11'd0);
		send_item(32'h0000_0000, 32'h0005_0000, 11'd1);
		send_item(32'h8000_0000, 32'h7FFF_FFFF, 11'd2);
		send_item(32'hFFFF_0000, 32'h0001_0000, 11'd1023);
		drain();

		// Moderate curve, then extreme coefficients that saturate
		write_coef(REG_CUBIC, 48'h0000_4000_0000);
		write_coef(REG_SQUARE, 48'hFFFF_8000_0000);
		write_coef(REG_LINEAR, 48'h0001_0000_0000);
		send_item(32'hFFFE_0000, 32'h0003_0000, 11'd7);
		send_item(32'h0000_0000, 32'h0000_0001, 11'd2047);
		send_item(32'h8000_0000, 32'h7FFF_FFFF, 11'd3);
		send_item(32'hFFFF_FFFF, 32'h0000_0000, 11'd2);
		drain();
		write_coef(REG_CUBIC, 48'h7FFF_FFFF_FFFF);
		write_coef(REG_SQUARE, 48'h7FFF_FFFF_FFFF);
		write_coef(REG_LINEAR, 48'h7FFF_FFFF_FFFF);
		send_item(32'h0000_0000, 32'h0001_0000, 11'd2);
		drain();
		write_coef(REG_CUBIC, 48'h8000_0000_0000);
		write_coef(REG_SQUARE, 48'h8000_0000_0000);
		write_coef(REG_LINEAR, 48'h8000_0000_0000);
		send_item(32'hFFFF_0000, 32'h0000_0000, 11'd2);
		send_item(32'h8000_0000, 32'h8000_1000, 11'd2);
		drain();

		// Random phases over the idling modes, new coefficients each phase
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 77 : 36) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 77 : 36) : 0;
			write_coef(REG_CUBIC, rand_coef());
			write_coef(REG_SQUARE, rand_coef());
			write_coef(REG_LINEAR, rand_coef());
			if (ph == 0)
				hold_req = 1'b1;
			for (int i = 0; i < 25; i++)
				send_random();
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("[cubic_arc_length_simpson] OK");
		else
			$display("[cubic_arc_length_simpson] ERROR");
		$finish;
	end
endmodule
